### rtl/core/ray_sphere_intersect_defines.svh
// Assertion macros for the ray/sphere intersection RTL.
// Define ASSERT_OFF to compile the assertions away.
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define RSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define RSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/rsi_pkg.sv
`default_nettype none

package rsi_pkg;

    // Defaults for the top-level parameters
    localparam int          FRAC_BITS_DEF     = 16;
    localparam logic [31:0] MISS_DISTANCE_DEF = 32'hFFFF_FFFF;

    // Radius register reset value (1.0 in Q16.16)
    localparam logic [30:0] RADIUS_RESET = 31'd65536;

    // Root bits produced by the square root chain, quotient bits by the divider
    localparam int SQ_BITS  = 64;
    localparam int DIV_BITS = 32;

    // Data carried along the square root chain
    typedef struct packed {
        logic [65:0]  rem;    // partial remainder
        logic [63:0]  root;   // root bits so far
        logic [127:0] rad;    // radicand, two bits consumed per cell
        logic [63:0]  hm;     // |h|
        logic         hneg;   // sign of h
        logic [63:0]  a;      // d.d
        logic         miss;
    } t_sq;

    // Data carried along the divider chain
    typedef struct packed {
        logic [95:0] num;     // partial numerator
        logic [31:0] quo;     // quotient bits so far
        logic [63:0] a;       // divisor
        logic        sat;     // quotient would not fit 32 bits
        logic        miss;
    } t_dv;

endpackage

`default_nettype wire

### rtl/core/ray_sphere_intersect.sv
// Channel   Direction  Handshake           Payload
// ray       in         i_valid / o_stall   i_origin_x/y/z, i_dir_x/y/z
// result    out        o_valid / i_stall   o_hit, o_distance
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_data (sphere radius)
//
// One ray per cycle while the output is not stalled; the pipeline is 6 front stages,
// 64 square root cells (one root bit each), 2 numerator stages, 32 divide
// cells (one quotient bit each) and the output register.
// Reset is synchronous, active low; it empties the pipeline and sets the
// radius to 1.0. A stall holds the output; upstream stages keep filling
// empty slots, so rays are taken until every stage holds one.
`default_nettype none

`include "ray_sphere_intersect_defines.svh"

module ray_sphere_intersect
    import rsi_pkg::*;
#(
    parameter int          FRAC_BITS     = FRAC_BITS_DEF,
    parameter logic [31:0] MISS_DISTANCE = MISS_DISTANCE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_origin_x,
    input  wire logic signed [31:0] i_origin_y,
    input  wire logic signed [31:0] i_origin_z,
    input  wire logic signed [31:0] i_dir_x,
    input  wire logic signed [31:0] i_dir_y,
    input  wire logic signed [31:0] i_dir_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_hit,
    output logic [31:0]             o_distance,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [30:0]        i_cfg_data
);

    typedef struct packed {
        logic [64:0] n;
        logic [63:0] a;
        logic        miss;
    } t_n1;

    logic [30:0] r_radius;
    logic        front_ready;

    logic sq_v   [SQ_BITS+1];
    logic sq_rdy [SQ_BITS+1];
    t_sq  sq_d   [SQ_BITS+1];

    logic dv_v   [DIV_BITS+1];
    logic dv_rdy [DIV_BITS+1];
    t_dv  dv_d   [DIV_BITS+1];

    logic        r_n1_v, n1_rdy;
    t_n1         r_n1, n_n1;
    logic        r_n2_v, n2_rdy;
    t_dv         r_n2, n_n2;
    logic [96:0] num_w;
    logic [96:0] lim;
    logic [63:0] s_root;

    logic        r_out_v, out_rdy;
    logic        r_hit, n_hit;
    logic [31:0] r_dist, n_dist;

    // Radius register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_data;
        end
    end

    assign o_stall = !front_ready;

    rsi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (front_ready),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_origin_z (i_origin_z),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_dir_z    (i_dir_z),
        .i_radius   (r_radius),
        .o_valid    (sq_v[0]),
        .i_ready    (sq_rdy[0]),
        .o_data     (sq_d[0])
    );

    // Square root chain
    for (genvar k = 0; k < SQ_BITS; k++) begin : g_sq
        rsi_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[k]),
            .o_ready (sq_rdy[k]),
            .i_data  (sq_d[k]),
            .o_valid (sq_v[k+1]),
            .i_ready (sq_rdy[k+1]),
            .o_data  (sq_d[k+1])
        );
    end

    // Ready chain through the numerator stages and the output register
    assign out_rdy          = !r_out_v || !i_stall;
    assign dv_rdy[DIV_BITS] = out_rdy;
    assign n2_rdy           = !r_n2_v || dv_rdy[0];
    assign n1_rdy           = !r_n1_v || n2_rdy;
    assign sq_rdy[SQ_BITS]  = n1_rdy;

    // Numerator stage 1: pick the root, -h - s or -h + s, or flag a miss if neither is positive
    assign s_root = sq_d[SQ_BITS].root;

    always_comb begin
        n_n1.a    = sq_d[SQ_BITS].a;
        n_n1.miss = sq_d[SQ_BITS].miss;
        n_n1.n    = '0;
        priority if (sq_d[SQ_BITS].hneg && (sq_d[SQ_BITS].hm > s_root)) begin
            n_n1.n = 65'(sq_d[SQ_BITS].hm - s_root);
        end else if (sq_d[SQ_BITS].hneg) begin
            n_n1.n = 65'(sq_d[SQ_BITS].hm) + 65'(s_root);
        end else if (s_root > sq_d[SQ_BITS].hm) begin
            n_n1.n = 65'(s_root - sq_d[SQ_BITS].hm);
        end else begin
            n_n1.miss = 1'b1;
        end
    end

    // Numerator stage 2: scale and check for saturation
    always_comb begin
        num_w = 97'(r_n1.n) << FRAC_BITS;
        lim   = {1'b0, r_n1.a, 32'd0};
        n_n2.num  = num_w[95:0];
        n_n2.quo  = '0;
        n_n2.a    = r_n1.a;
        n_n2.sat  = (num_w >= lim);
        n_n2.miss = r_n1.miss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n1_v <= 1'b0;
            r_n2_v <= 1'b0;
        end else begin
            if (n1_rdy) begin
                r_n1_v <= sq_v[SQ_BITS];
            end
            if (n2_rdy) begin
                r_n2_v <= r_n1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n1_rdy) begin
            r_n1 <= n_n1;
        end
        if (n2_rdy) begin
            r_n2 <= n_n2;
        end
    end

    assign dv_v[0] = r_n2_v;
    assign dv_d[0] = r_n2;

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_dv
        rsi_div_cell #(
            .SHIFT (DIV_BITS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[k]),
            .o_ready (dv_rdy[k]),
            .i_data  (dv_d[k]),
            .o_valid (dv_v[k+1]),
            .i_ready (dv_rdy[k+1]),
            .o_data  (dv_d[k+1])
        );
    end

    // Output register
    always_comb begin
        n_hit  = !dv_d[DIV_BITS].miss;
        n_dist = dv_d[DIV_BITS].miss ? MISS_DISTANCE
               : (dv_d[DIV_BITS].sat ? 32'hFFFF_FFFF : dv_d[DIV_BITS].quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_rdy) begin
            r_out_v <= dv_v[DIV_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_hit  <= n_hit;
            r_dist <= n_dist;
        end
    end

    assign o_valid    = r_out_v;
    assign o_hit      = r_hit;
    assign o_distance = r_dist;

    // An empty output register means the whole chain can take a ray
    `RSI_ASSERT_IMP(a_empty_takes, i_clk, i_rst_n, !r_out_v, !o_stall)
    // Misses always report the miss distance
    `RSI_ASSERT_IMP(a_miss_dist, i_clk, i_rst_n, r_out_v && !r_hit,
        r_dist == MISS_DISTANCE)
    // A radius write lands in the register
    `RSI_ASSERT_NXT(a_cfg_write, i_clk, i_rst_n, i_rst_n && i_cfg_valid,
        r_radius == $past(i_cfg_data))

endmodule

`default_nettype wire

### rtl/core/rsi_front.sv
`default_nettype none

// Dot products, discriminant and miss test ahead of the square root chain.
module rsi_front
    import rsi_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_origin_x,
    input  wire logic signed [31:0] i_origin_y,
    input  wire logic signed [31:0] i_origin_z,
    input  wire logic signed [31:0] i_dir_x,
    input  wire logic signed [31:0] i_dir_y,
    input  wire logic signed [31:0] i_dir_z,
    input  wire logic [30:0]        i_radius,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_sq                     o_data
);

    typedef struct packed {
        logic [2:0][63:0] pdd;
        logic [2:0][63:0] poo;
        logic [2:0][63:0] pod;
        logic [2:0]       hs;
        logic [61:0]      r2;
    } t_s1;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] o2;
        logic [63:0] hp;
        logic [63:0] hn;
        logic [61:0] r2;
    } t_s2;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] hm;
        logic [63:0] cm;
        logic        hneg;
        logic        cneg;
        logic        azero;
    } t_s3;

    typedef struct packed {
        logic [3:0][63:0] hpp;
        logic [3:0][63:0] cpp;
        logic [63:0]      a;
        logic [63:0]      hm;
        logic             hneg;
        logic             cneg;
        logic             azero;
    } t_s4;

    typedef struct packed {
        logic [127:0] hm2;
        logic [127:0] ac;
        logic [63:0]  a;
        logic [63:0]  hm;
        logic         hneg;
        logic         cneg;
        logic         azero;
    } t_s5;

    localparam int NSTG = 6;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] rdy;
    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;
    t_sq r_out, n_out;
    logic [2:0][31:0] om;
    logic [2:0][31:0] dm;

    // Stage ready chain: a stage loads when empty or when its successor moves
    always_comb begin
        rdy[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[NSTG-1];
    assign o_data  = r_out;

    // Stage 1: magnitudes and the 32x32 products
    always_comb begin
        om[0] = mag32(i_origin_x);
        om[1] = mag32(i_origin_y);
        om[2] = mag32(i_origin_z);
        dm[0] = mag32(i_dir_x);
        dm[1] = mag32(i_dir_y);
        dm[2] = mag32(i_dir_z);
        n_s1.hs[0] = i_origin_x[31] ^ i_dir_x[31];
        n_s1.hs[1] = i_origin_y[31] ^ i_dir_y[31];
        n_s1.hs[2] = i_origin_z[31] ^ i_dir_z[31];
        for (int i = 0; i < 3; i++) begin
            n_s1.pdd[i] = 64'(dm[i]) * 64'(dm[i]);
            n_s1.poo[i] = 64'(om[i]) * 64'(om[i]);
            n_s1.pod[i] = 64'(om[i]) * 64'(dm[i]);
        end
        n_s1.r2 = 62'(i_radius) * 62'(i_radius);
    end

    // Stage 2: sums of products, h split by sign
    always_comb begin
        n_s2.a  = r_s1.pdd[0] + r_s1.pdd[1] + r_s1.pdd[2];
        n_s2.o2 = r_s1.poo[0] + r_s1.poo[1] + r_s1.poo[2];
        n_s2.hp = (r_s1.hs[0] ? 64'd0 : r_s1.pod[0]) + (r_s1.hs[1] ? 64'd0 : r_s1.pod[1])
                + (r_s1.hs[2] ? 64'd0 : r_s1.pod[2]);
        n_s2.hn = (r_s1.hs[0] ? r_s1.pod[0] : 64'd0) + (r_s1.hs[1] ? r_s1.pod[1] : 64'd0)
                + (r_s1.hs[2] ? r_s1.pod[2] : 64'd0);
        n_s2.r2 = r_s1.r2;
    end

    // Stage 3: sign and magnitude of h and c
    always_comb begin
        n_s3.a     = r_s2.a;
        n_s3.azero = (r_s2.a == 64'd0);
        n_s3.hneg  = (r_s2.hp < r_s2.hn);
        n_s3.hm    = n_s3.hneg ? (r_s2.hn - r_s2.hp) : (r_s2.hp - r_s2.hn);
        n_s3.cneg  = (r_s2.o2 < 64'(r_s2.r2));
        n_s3.cm    = n_s3.cneg ? (64'(r_s2.r2) - r_s2.o2) : (r_s2.o2 - 64'(r_s2.r2));
    end

    // Stage 4: 32x32 partial products of h*h and a*c
    always_comb begin
        n_s4.hpp[0] = 64'(r_s3.hm[31:0])  * 64'(r_s3.hm[31:0]);
        n_s4.hpp[1] = 64'(r_s3.hm[31:0])  * 64'(r_s3.hm[63:32]);
        n_s4.hpp[2] = 64'(r_s3.hm[63:32]) * 64'(r_s3.hm[31:0]);
        n_s4.hpp[3] = 64'(r_s3.hm[63:32]) * 64'(r_s3.hm[63:32]);
        n_s4.cpp[0] = 64'(r_s3.a[31:0])   * 64'(r_s3.cm[31:0]);
        n_s4.cpp[1] = 64'(r_s3.a[31:0])   * 64'(r_s3.cm[63:32]);
        n_s4.cpp[2] = 64'(r_s3.a[63:32])  * 64'(r_s3.cm[31:0]);
        n_s4.cpp[3] = 64'(r_s3.a[63:32])  * 64'(r_s3.cm[63:32]);
        n_s4.a      = r_s3.a;
        n_s4.hm     = r_s3.hm;
        n_s4.hneg   = r_s3.hneg;
        n_s4.cneg   = r_s3.cneg;
        n_s4.azero  = r_s3.azero;
    end

    // Stage 5: assemble the 128-bit products
    always_comb begin
        n_s5.hm2 = {r_s4.hpp[3], r_s4.hpp[0]} + {32'd0, r_s4.hpp[1], 32'd0}
                 + {32'd0, r_s4.hpp[2], 32'd0};
        n_s5.ac  = {r_s4.cpp[3], r_s4.cpp[0]} + {32'd0, r_s4.cpp[1], 32'd0}
                 + {32'd0, r_s4.cpp[2], 32'd0};
        n_s5.a     = r_s4.a;
        n_s5.hm    = r_s4.hm;
        n_s5.hneg  = r_s4.hneg;
        n_s5.cneg  = r_s4.cneg;
        n_s5.azero = r_s4.azero;
    end

    // Stage 6: discriminant (wraps at 128 bits) and early miss
    always_comb begin
        n_out.rem  = '0;
        n_out.root = '0;
        n_out.rad  = r_s5.cneg ? (r_s5.hm2 + r_s5.ac) : (r_s5.hm2 - r_s5.ac);
        n_out.hm   = r_s5.hm;
        n_out.hneg = r_s5.hneg;
        n_out.a    = r_s5.a;
        n_out.miss = r_s5.azero || (!r_s5.cneg && (r_s5.hm2 < r_s5.ac));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s1 <= n_s1;
        end
        if (rdy[1]) begin
            r_s2 <= n_s2;
        end
        if (rdy[2]) begin
            r_s3 <= n_s3;
        end
        if (rdy[3]) begin
            r_s4 <= n_s4;
        end
        if (rdy[4]) begin
            r_s5 <= n_s5;
        end
        if (rdy[5]) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rsi_sqrt_cell.sv
`default_nettype none

// One root bit per cell: restoring square root step.
module rsi_sqrt_cell
    import rsi_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_sq  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_sq       o_data
);

    logic        r_valid;
    t_sq         r_data, n_data;
    logic [67:0] rem_sh;
    logic [67:0] trial;
    logic        ge;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Bring down two radicand bits, try root*4+1
    always_comb begin
        rem_sh = {i_data.rem, i_data.rad[127:126]};
        trial  = {2'b00, i_data.root, 2'b01};
        ge     = (rem_sh >= trial);
        n_data      = i_data;
        n_data.rem  = ge ? 66'(rem_sh - trial) : 66'(rem_sh);
        n_data.root = {i_data.root[62:0], ge};
        n_data.rad  = {i_data.rad[125:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rsi_div_cell.sv
`default_nettype none

// One quotient bit per cell: compare and subtract the shifted divisor.
module rsi_div_cell
    import rsi_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_dv  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_dv       o_data
);

    logic        r_valid;
    t_dv         r_data, n_data;
    logic [95:0] trial;
    logic        ge;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        trial = {32'd0, i_data.a} << SHIFT;
        ge    = (i_data.num >= trial);
        n_data = i_data;
        n_data.num = ge ? (i_data.num - trial) : i_data.num;
        n_data.quo[SHIFT] = ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

### bench/tb_ray_sphere_intersect.sv
`timescale 1ns / 1ps

module tb_ray_sphere_intersect;
    import rsi_pkg::*;

    localparam int          LATENCY   = 105;
    localparam int          MAX_CYC   = 400000;
    localparam logic [31:0] MISS_DIST = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] ox, oy, oz, dx, dy, dz;
    } t_ray;

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
    } t_hit;

    logic               i_clk, i_rst_n;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic               o_stall, o_valid, o_hit;
    logic signed [31:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [31:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic [31:0]        o_distance;
    logic               i_cfg_valid, o_cfg_ready;
    logic [30:0]        i_cfg_data;

    t_ray        pending_rays[$];
    t_hit        expected_hits[$];
    logic [30:0] radius;
    int          cycle = 0, errors = 0, hits_seen = 0, results_seen = 0, rays_sent = 0;
    int          hold_cnt = 0;     // cycles left in the long output hold-off
    int          quiet_cnt = 0;    // cycles left with no idling on either side
    logic        hold_done = 1'b0;
    logic        quiet_done = 1'b0;

    ray_sphere_intersect DUT (.*);

    // Intersection predictor: full-width quadratic, floor sqrt, floor divide
    function automatic t_hit trace_ray(t_ray r, logic [30:0] rad);
        logic [31:0]  comp[6];
        logic [63:0]  mag[6];
        logic         neg[6];
        logic [63:0]  a, o2, hp, hn, hm, r2, cm, s, cand;
        logic [127:0] d, ac, num;
        logic         hneg, cneg;
        t_hit         res;
        comp = '{r.ox, r.oy, r.oz, r.dx, r.dy, r.dz};
        for (int i = 0; i < 6; i++) begin
            neg[i] = comp[i][31];
            mag[i] = neg[i] ? 64'h1_0000_0000 - {32'b0, comp[i]} : {32'b0, comp[i]};
        end
        a = '0; o2 = '0; hp = '0; hn = '0;
        for (int i = 0; i < 3; i++) begin
            a  += mag[3+i] * mag[3+i];
            o2 += mag[i] * mag[i];
            if (neg[i] != neg[3+i]) hn += mag[i] * mag[3+i];
            else                    hp += mag[i] * mag[3+i];
        end
        hneg = hp < hn;
        hm   = hneg ? hn - hp : hp - hn;
        r2   = {33'b0, rad} * {33'b0, rad};
        cneg = o2 < r2;
        cm   = cneg ? r2 - o2 : o2 - r2;
        res  = '{hit: 1'b0, distance: MISS_DIST};
        if (a == 0) return res;
        d  = {64'b0, hm} * {64'b0, hm};
        ac = {64'b0, a} * {64'b0, cm};
        if (cneg) d = d + ac;
        else if (d < ac) return res;
        else d = d - ac;
        s = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = s | (64'd1 << b);
            if ({64'b0, cand} * {64'b0, cand} <= d) s = cand;
        end
        if (hneg && hm > s) num = {64'b0, hm - s};
        else if (hneg)      num = {64'b0, hm} + {64'b0, s};
        else if (s > hm)    num = {64'b0, s - hm};
        else return res;
        num = num << 16;
        res.hit = 1'b1;
        if (num >= {32'b0, a, 32'b0}) res.distance = 32'hFFFF_FFFF;
        else res.distance = 32'(num / {64'b0, a});
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle, what, got, want);
        errors++;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYC) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Ray driver: idles at random except in the quiet window
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_hits.push_back(trace_ray({i_origin_x, i_origin_y, i_origin_z,
                                                   i_dir_x, i_dir_y, i_dir_z}, radius));
                rays_sent++;
            end
            if (!(i_valid && o_stall)) begin
                if (pending_rays.size() > 0 &&
                    (quiet_cnt > 0 || $urandom_range(0, 99) >= 37)) begin
                    t_ray r;
                    r = pending_rays.pop_front();
                    i_valid    <= 1'b1;
                    i_origin_x <= r.ox; i_origin_y <= r.oy; i_origin_z <= r.oz;
                    i_dir_x    <= r.dx; i_dir_y    <= r.dy; i_dir_z    <= r.dz;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stall, one long hold-off to fill the pipe, one quiet window
    always @(posedge i_clk) begin
        if (!hold_done && rays_sent >= 200) begin
            hold_done <= 1'b1;
            hold_cnt  <= 400;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
        if (!quiet_done && rays_sent >= 500) begin
            quiet_done <= 1'b1;
            quiet_cnt  <= 300;
        end else if (quiet_cnt > 0) begin
            quiet_cnt <= quiet_cnt - 1;
        end
        if (hold_cnt > 0) i_stall <= 1'b1;
        else if (quiet_cnt > 0) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 99) < 37);
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_hits.size() == 0) begin
                report_mismatch("unexpected transfer", o_distance, 32'h0);
            end else begin
                t_hit want;
                want = expected_hits.pop_front();
                if (o_hit !== want.hit) report_mismatch("hit", {31'b0, o_hit}, {31'b0, want.hit});
                if (o_distance !== want.distance)
                    report_mismatch("distance", o_distance, want.distance);
                if (want.hit) hits_seen++;
            end
        end
    end

    function automatic logic signed [31:0] rand_comp();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    // Mostly rays aimed near the center, the rest arbitrary
    function automatic t_ray rand_ray();
        t_ray r;
        int   sh;
        if ($urandom_range(0, 99) < 65) begin
            sh   = $urandom_range(8, 22);
            r.ox = $signed($urandom) >>> (32 - sh - 4);
            r.oy = $signed($urandom) >>> (32 - sh - 4);
            r.oz = $signed($urandom) >>> (32 - sh - 4);
            r.dx = -r.ox + ($signed($urandom) >>> (32 - sh));
            r.dy = -r.oy + ($signed($urandom) >>> (32 - sh));
            r.dz = -r.oz + ($signed($urandom) >>> (32 - sh));
            if ($urandom_range(0, 3) == 0) r.dx = r.dx >>> $urandom_range(0, 12);
        end else begin
            r = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        end
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_rays.size() > 0 || i_valid || expected_hits.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [30:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        radius = value;
    endtask

    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    // Stimulus and end of run
    initial begin
        logic [30:0] radii[5];
        radii = '{31'd0, 31'h7FFF_FFFF, 31'd1 << 20, 31'd1, 31'd65536};
        radius      = RADIUS_RESET;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rays under the reset radius
        pending_rays.push_back('{0, 0, 0, 0, 0, 0});                  // zero direction
        pending_rays.push_back('{-2*ONE, 0, 0, ONE, 0, 0});           // straight hit
        pending_rays.push_back('{-2*ONE, 0, 0, -ONE, 0, 0});          // pointing away
        pending_rays.push_back('{0, 0, 0, 0, ONE, 0});                // from inside
        pending_rays.push_back('{-2*ONE, 5*ONE, 0, ONE, 0, 0});       // negative discriminant
        pending_rays.push_back('{-2*ONE, 0, 0, 32'sh7FFF_FFFF, 0, 0}); // tiny positive root
        pending_rays.push_back('{-MAXV, 0, 0, 1, 0, 0});               // saturated distance
        pending_rays.push_back('{-ONE, 0, 0, ONE, 0, 0});              // origin on surface
        pending_rays.push_back('{MINV, MINV, MINV, MINV, MINV, MINV});
        pending_rays.push_back('{MAXV, MAXV, MAXV, MINV, MINV, MINV});
        pending_rays.push_back('{MINV, MAXV, MINV, MAXV, MINV, MAXV});
        pending_rays.push_back('{0, 0, 0, MAXV, MAXV, MAXV});
        pending_rays.push_back('{-1, -1, -1, 1, 1, 1});
        pending_rays.push_back('{ONE, -ONE, 0, -1, 1, 0});
        pending_rays.push_back('{-32'sd3, 0, 0, 32'sd1, 0, 0});
        pending_rays.push_back('{0, 0, 0, -32'sd1, -32'sd1, -32'sd1});
        for (int i = 0; i < 180; i++) pending_rays.push_back(rand_ray());
        wait_drained();

        // Random phases at several radii, extremes included
        foreach (radii[p]) begin
            write_radius(p == 2 ? 31'($urandom) >> $urandom_range(0, 20) : radii[p]);
            for (int i = 0; i < 150; i++) pending_rays.push_back(rand_ray());
            wait_drained();
        end

        $display("covered %0d rays over %0d radius settings, %0d results, %0d hits",
                 rays_sent, 6, results_seen, hits_seen);
        $display("zero direction, misses, saturation, full-scale values and a long output stall");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/rsi_pkg.sv
rtl/core/rsi_front.sv
rtl/core/rsi_sqrt_cell.sv
rtl/core/rsi_div_cell.sv
rtl/core/ray_sphere_intersect.sv
bench/tb_ray_sphere_intersect.sv
